@@ src/s2d_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// s2d_pkg: shared types and constants for the space-to-depth address generator
// Field widths, register indexes, status codes and the result record.
// ----------------------------------------------------------------------------
package s2d_pkg;

    // Configuration register widths.
    localparam int BATCH_W = 9;
    localparam int CHAN_W  = 13;
    localparam int DIM_W   = 13;
    localparam int BS_W    = 5;
    localparam int EB_W    = 4;

    // Input coordinate widths.
    localparam int NIDX_W = 8;
    localparam int OC_W   = 20;
    localparam int ROW_W  = 12;
    localparam int COL_W  = 12;

    // Result widths.
    localparam int OFF_W = 32;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Derived internal widths.
    localparam int BS2_W  = 2 * BS_W;          // block size squared
    localparam int COUT_W = CHAN_W + BS2_W;    // output channel count
    localparam int SPAN_W = ROW_W + BS_W;      // coordinate times block size

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_SHAPE = 2'd1,
        ST_RANGE = 2'd2,
        ST_OVER  = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BATCH_COUNT   = 3'd0,
        CFG_CHANNEL_COUNT = 3'd1,
        CFG_IN_HEIGHT     = 3'd2,
        CFG_IN_WIDTH      = 3'd3,
        CFG_BLOCK_SIZE    = 3'd4,
        CFG_ELEMENT_BYTES = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [OFF_W-1:0] src;
        logic [OFF_W-1:0] dst;
        t_status          status;
    } t_result;

endpackage
`default_nettype wire

@@ src/s2d_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// s2d_div: pipelined restoring divider
// Produces QUO_W quotient bits over STAGES register stages, up to SPS bits per
// stage. The numerator must stay below the divisor times 2**QUO_W for the
// quotient to be exact, and NUM_W must be at least DEN_W.
// ----------------------------------------------------------------------------
module s2d_div #(
    parameter int NUM_W  = 20,
    parameter int DEN_W  = 13,
    parameter int QUO_W  = 10,
    parameter int STAGES = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic      [QUO_W-1:0] o_quo,
    output logic      [DEN_W-1:0] o_rem
);

    localparam int SPS   = (QUO_W + STAGES - 1) / STAGES;
    localparam int CMP_W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

    logic [NUM_W-1:0] r_rem [STAGES];
    logic [QUO_W-1:0] r_quo [STAGES];
    logic [DEN_W-1:0] r_den [STAGES];

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        logic [NUM_W-1:0] w_rem_in;
        logic [QUO_W-1:0] w_quo_in;
        logic [DEN_W-1:0] w_den_in;
        logic [NUM_W-1:0] n_rem;
        logic [QUO_W-1:0] n_quo;

        // Stage input comes from the ports or from the stage before.
        if (k == 0) begin : g_first
            assign w_rem_in = i_num;
            assign w_quo_in = '0;
            assign w_den_in = i_den;
        end else begin : g_next
            assign w_rem_in = r_rem[k-1];
            assign w_quo_in = r_quo[k-1];
            assign w_den_in = r_den[k-1];
        end

        // This stage's share of trial subtractions, most significant bit first.
        always_comb begin
            logic [CMP_W-1:0] v_rem;
            logic [CMP_W-1:0] v_trial;
            v_rem   = CMP_W'(w_rem_in);
            v_trial = '0;
            n_quo   = w_quo_in;
            for (int b = QUO_W - 1 - k * SPS; b >= QUO_W - (k + 1) * SPS && b >= 0; b--) begin
                v_trial = CMP_W'(w_den_in) << b;
                if (v_rem >= v_trial) begin
                    v_rem    = v_rem - v_trial;
                    n_quo[b] = 1'b1;
                end
            end
            n_rem = v_rem[NUM_W-1:0];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem;
                r_quo[k] <= n_quo;
                r_den[k] <= w_den_in;
            end
        end
    end

    assign o_quo = r_quo[STAGES-1];
    assign o_rem = r_rem[STAGES-1][DEN_W-1:0];

endmodule
`default_nettype wire

@@ src/space_to_depth_address_gen.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// space_to_depth_address_gen: SpaceToDepth source and destination offsets
// Maps one output coordinate of an NCHW space-to-depth rearrangement to the
// byte offsets of its element in the input and output tensors, with status.
// ----------------------------------------------------------------------------
// The block takes one coordinate beat per clock while o_in_stall is low and
// returns one result beat per coordinate, in order. Without stalls the rate
// of one beat per cycle is set by the nine-stage pipeline: the channel and
// shape divisions run as pipelined restoring dividers (ceil(QUO_W/STAGES)
// quotient bits per stage at most); offsets take one multiply-add per stage.
// A two-entry output register absorbs a stalled result while the pipeline
// keeps its contents; input stall rises only once both entries are full.
// Configuration is written through a separate always-ready port and must be
// written only while no coordinate is in flight. Status priority is shape,
// then range, then overflow; shape and range faults return zero offsets, and
// each offset saturates on its own at 2**min(OFFSET_BITS, 32) - 1.
// ----------------------------------------------------------------------------
module space_to_depth_address_gen
    import s2d_pkg::*;
#(
    parameter int OFFSET_BITS = 32,
    parameter int MAX_BLOCK   = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Configuration write port
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    // Coordinate input channel
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [NIDX_W-1:0]     i_batch_index,
    input  wire logic [OC_W-1:0]       i_out_channel,
    input  wire logic [ROW_W-1:0]      i_out_row,
    input  wire logic [COL_W-1:0]      i_out_col,
    // Result channel
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [OFF_W-1:0]           o_src_offset,
    output logic [OFF_W-1:0]           o_dst_offset,
    output logic [1:0]                 o_status
);

    localparam int LIM_BITS = (OFFSET_BITS < OFF_W) ? OFFSET_BITS : OFF_W;
    localparam logic [OFF_W:0] LIMIT_X = ((OFF_W + 1)'(1) << LIM_BITS) - (OFF_W + 1)'(1);
    localparam logic [OFF_W-1:0] LIMIT = LIMIT_X[OFF_W-1:0];

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [BATCH_W-1:0] r_batch_count;
    logic [CHAN_W-1:0]  r_channel_count;
    logic [DIM_W-1:0]   r_in_height;
    logic [DIM_W-1:0]   r_in_width;
    logic [BS_W-1:0]    r_block_size;
    logic [EB_W-1:0]    r_element_bytes;

    assign o_cfg_ready = 1'b1;

    // Register writes by index; unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_batch_count   <= BATCH_W'(1);
            r_channel_count <= CHAN_W'(1);
            r_in_height     <= DIM_W'(1);
            r_in_width      <= DIM_W'(1);
            r_block_size    <= BS_W'(1);
            r_element_bytes <= EB_W'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_BATCH_COUNT:   r_batch_count   <= i_cfg_data[BATCH_W-1:0];
                CFG_CHANNEL_COUNT: r_channel_count <= i_cfg_data[CHAN_W-1:0];
                CFG_IN_HEIGHT:     r_in_height     <= i_cfg_data[DIM_W-1:0];
                CFG_IN_WIDTH:      r_in_width      <= i_cfg_data[DIM_W-1:0];
                CFG_BLOCK_SIZE:    r_block_size    <= i_cfg_data[BS_W-1:0];
                CFG_ELEMENT_BYTES: r_element_bytes <= i_cfg_data[EB_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control
    // ------------------------------------------------------------------
    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    t_result w_result;
    logic    w_en;
    logic    w_take;

    // The whole pipeline moves unless the skid entry holds a result.
    assign w_en       = !r_skid_valid;
    assign o_in_stall = r_skid_valid;
    assign w_take     = r_out_valid && !i_out_stall;

    // ------------------------------------------------------------------
    // Stage registers
    // ------------------------------------------------------------------
    logic r_s0_v, r_s1_v, r_s2_v, r_s3_v, r_s4_v, r_s5_v, r_s6_v, r_s7_v, r_s8_v;

    logic [NIDX_W-1:0] r_s0_n, r_s1_n, r_s2_n, r_s3_n;
    logic [OC_W-1:0]   r_s0_oc, r_s1_oc, r_s2_oc, r_s3_oc;
    logic [ROW_W-1:0]  r_s0_oh, r_s1_oh, r_s2_oh, r_s3_oh, r_s4_oh;
    logic [COL_W-1:0]  r_s0_ow, r_s1_ow, r_s2_ow, r_s3_ow, r_s4_ow, r_s5_ow;

    logic [BS2_W-1:0]  r_s1_bs2;
    logic              r_s1_bsbad, r_s2_bsbad, r_s3_bsbad;
    logic [SPAN_W-1:0] r_s1_ohbs, r_s2_ohbs, r_s3_ohbs, r_s4_ohbs, r_s5_ohbs;
    logic [SPAN_W-1:0] r_s1_owbs, r_s2_owbs, r_s3_owbs, r_s4_owbs, r_s5_owbs;
    logic              r_s1_nok, r_s2_inok;
    logic [COUT_W-1:0] r_s2_cout, r_s3_cout;
    logic              r_s3_rng, r_s4_rng, r_s5_rng, r_s6_rng, r_s7_rng, r_s8_rng;
    logic              r_s4_shape, r_s5_shape, r_s6_shape, r_s7_shape, r_s8_shape;
    logic [DIM_W-1:0]  r_s4_hq;
    logic [DIM_W-1:0]  r_s4_wq, r_s5_wq;
    logic [OFF_W-1:0]  r_s4_d, r_s5_d, r_s6_d, r_s7_d, r_s8_d;
    logic              r_s5_dbig, r_s6_dbig, r_s7_dbig, r_s8_dbig;
    logic [CHAN_W+NIDX_W:0] r_s4_a;
    logic [OFF_W-1:0]  r_s5_a, r_s6_a, r_s7_a, r_s8_a;
    logic              r_s5_abig, r_s6_abig, r_s7_abig, r_s8_abig;
    logic [SPAN_W:0]   r_s6_iw;

    // ------------------------------------------------------------------
    // Dividers: oc / C and the two shape divisions start with the beat;
    // the block quotient is split into row and column after stage 3.
    // ------------------------------------------------------------------
    logic [BS2_W-1:0]  w_q;
    logic [CHAN_W-1:0] w_c;
    logic [DIM_W-1:0]  w_hq, w_wq;
    logic [BS_W-1:0]   w_hr, w_wr;
    logic [BS_W-1:0]   w_bh, w_bw;

    s2d_div #(
        .NUM_W  (OC_W),
        .DEN_W  (CHAN_W),
        .QUO_W  (BS2_W),
        .STAGES (4)
    ) u_div_chan (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (i_out_channel),
        .i_den (r_channel_count),
        .o_quo (w_q),
        .o_rem (w_c)
    );

    s2d_div #(
        .NUM_W  (DIM_W),
        .DEN_W  (BS_W),
        .QUO_W  (DIM_W),
        .STAGES (4)
    ) u_div_height (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_in_height),
        .i_den (r_block_size),
        .o_quo (w_hq),
        .o_rem (w_hr)
    );

    s2d_div #(
        .NUM_W  (DIM_W),
        .DEN_W  (BS_W),
        .QUO_W  (DIM_W),
        .STAGES (4)
    ) u_div_width (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_in_width),
        .i_den (r_block_size),
        .o_quo (w_wq),
        .o_rem (w_wr)
    );

    s2d_div #(
        .NUM_W  (BS2_W),
        .DEN_W  (BS_W),
        .QUO_W  (BS_W),
        .STAGES (2)
    ) u_div_block (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (w_q),
        .i_den (r_block_size),
        .o_quo (w_bh),
        .o_rem (w_bw)
    );

    // ------------------------------------------------------------------
    // Stage arithmetic
    // ------------------------------------------------------------------
    logic [BS2_W-1:0]       n_s1_bs2;
    logic [SPAN_W-1:0]      n_s1_ohbs, n_s1_owbs;
    logic                   n_s1_bsbad, n_s1_nok;
    logic [COUT_W-1:0]      n_s2_cout;
    logic                   n_s2_inok;
    logic                   n_s3_rng;
    logic [OFF_W-1:0]       n_s4_d;
    logic [CHAN_W+NIDX_W:0] n_s4_a;
    logic                   n_s4_shape;
    logic [44:0]            w_s5_dfull;
    logic [34:0]            w_s5_afull;
    logic [44:0]            w_s6_dfull;
    logic [33:0]            w_s6_afull;
    logic [SPAN_W:0]        n_s6_iw;
    logic [44:0]            w_s7_afull;
    logic [35:0]            w_s7_dfull;
    logic [35:0]            w_s8_afull;
    logic                   w_eb_zero;

    assign w_eb_zero = (r_element_bytes == '0);

    // Stage 1: block size checks, block size squared, range products.
    always_comb begin
        n_s1_bs2   = BS2_W'(r_block_size) * BS2_W'(r_block_size);
        n_s1_bsbad = (r_block_size == '0) || (32'(r_block_size) > 32'(MAX_BLOCK));
        n_s1_ohbs  = SPAN_W'(r_s0_oh) * SPAN_W'(r_block_size);
        n_s1_owbs  = SPAN_W'(r_s0_ow) * SPAN_W'(r_block_size);
        n_s1_nok   = BATCH_W'(r_s0_n) < r_batch_count;
    end

    // Stage 2: output channel count; batch index in range, row and column fit below H/bs, W/bs.
    always_comb begin
        n_s2_cout = COUT_W'(r_channel_count) * COUT_W'(r_s1_bs2);
        n_s2_inok = r_s1_nok
            && ((SPAN_W + 1)'(r_s1_ohbs) + (SPAN_W + 1)'(r_block_size)
                <= (SPAN_W + 1)'(r_in_height))
            && ((SPAN_W + 1)'(r_s1_owbs) + (SPAN_W + 1)'(r_block_size)
                <= (SPAN_W + 1)'(r_in_width));
    end

    // Stage 3: combined range flag for batch, row, column and output channel.
    assign n_s3_rng = !(r_s2_inok && (COUT_W'(r_s2_oc) < r_s2_cout));

    // Stage 4: first terms of both offsets and the shape check (block size, divisibility).
    always_comb begin
        n_s4_d = OFF_W'(r_s3_n) * OFF_W'(r_s3_cout) + OFF_W'(r_s3_oc);
        n_s4_a = (CHAN_W + NIDX_W + 1)'(r_s3_n) * (CHAN_W + NIDX_W + 1)'(r_channel_count)
               + (CHAN_W + NIDX_W + 1)'(w_c);
        n_s4_shape = r_s3_bsbad || (w_hr != '0) || (w_wr != '0);
    end

    // Stages 5 to 8 keep 32 bits plus a sticky flag for anything above.
    assign w_s5_dfull = 45'(r_s4_d) * 45'(r_s4_hq) + 45'(r_s4_oh);
    assign w_s5_afull = 35'(r_s4_a) * 35'(r_in_height);
    assign w_s6_dfull = 45'(r_s5_d) * 45'(r_s5_wq) + 45'(r_s5_ow);
    assign w_s6_afull = 34'(r_s5_a) + 34'(r_s5_ohbs) + 34'(w_bh);
    assign n_s6_iw    = (SPAN_W + 1)'(r_s5_owbs) + (SPAN_W + 1)'(w_bw);
    assign w_s7_afull = 45'(r_s6_a) * 45'(r_in_width) + 45'(r_s6_iw);
    assign w_s7_dfull = 36'(r_s6_d) * 36'(r_element_bytes);
    assign w_s8_afull = 36'(r_s7_a) * 36'(r_element_bytes);

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
            r_s5_v <= 1'b0;
            r_s6_v <= 1'b0;
            r_s7_v <= 1'b0;
            r_s8_v <= 1'b0;
        end else if (w_en) begin
            r_s0_v <= i_in_valid;
            r_s1_v <= r_s0_v;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v;
            r_s5_v <= r_s4_v;
            r_s6_v <= r_s5_v;
            r_s7_v <= r_s6_v;
            r_s8_v <= r_s7_v;
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // Stage 0
            r_s0_n  <= i_batch_index;
            r_s0_oc <= i_out_channel;
            r_s0_oh <= i_out_row;
            r_s0_ow <= i_out_col;
            // Stage 1
            r_s1_n     <= r_s0_n;
            r_s1_oc    <= r_s0_oc;
            r_s1_oh    <= r_s0_oh;
            r_s1_ow    <= r_s0_ow;
            r_s1_bs2   <= n_s1_bs2;
            r_s1_bsbad <= n_s1_bsbad;
            r_s1_ohbs  <= n_s1_ohbs;
            r_s1_owbs  <= n_s1_owbs;
            r_s1_nok   <= n_s1_nok;
            // Stage 2
            r_s2_n     <= r_s1_n;
            r_s2_oc    <= r_s1_oc;
            r_s2_oh    <= r_s1_oh;
            r_s2_ow    <= r_s1_ow;
            r_s2_cout  <= n_s2_cout;
            r_s2_bsbad <= r_s1_bsbad;
            r_s2_ohbs  <= r_s1_ohbs;
            r_s2_owbs  <= r_s1_owbs;
            r_s2_inok  <= n_s2_inok;
            // Stage 3
            r_s3_n     <= r_s2_n;
            r_s3_oc    <= r_s2_oc;
            r_s3_oh    <= r_s2_oh;
            r_s3_ow    <= r_s2_ow;
            r_s3_cout  <= r_s2_cout;
            r_s3_bsbad <= r_s2_bsbad;
            r_s3_ohbs  <= r_s2_ohbs;
            r_s3_owbs  <= r_s2_owbs;
            r_s3_rng   <= n_s3_rng;
            // Stage 4
            r_s4_oh    <= r_s3_oh;
            r_s4_ow    <= r_s3_ow;
            r_s4_ohbs  <= r_s3_ohbs;
            r_s4_owbs  <= r_s3_owbs;
            r_s4_hq    <= w_hq;
            r_s4_wq    <= w_wq;
            r_s4_shape <= n_s4_shape;
            r_s4_rng   <= r_s3_rng;
            r_s4_d     <= n_s4_d;
            r_s4_a     <= n_s4_a;
            // Stage 5
            r_s5_ow    <= r_s4_ow;
            r_s5_ohbs  <= r_s4_ohbs;
            r_s5_owbs  <= r_s4_owbs;
            r_s5_wq    <= r_s4_wq;
            r_s5_shape <= r_s4_shape;
            r_s5_rng   <= r_s4_rng;
            r_s5_d     <= w_s5_dfull[OFF_W-1:0];
            r_s5_dbig  <= |w_s5_dfull[44:OFF_W];
            r_s5_a     <= w_s5_afull[OFF_W-1:0];
            r_s5_abig  <= |w_s5_afull[34:OFF_W];
            // Stage 6
            r_s6_shape <= r_s5_shape;
            r_s6_rng   <= r_s5_rng;
            r_s6_d     <= w_s6_dfull[OFF_W-1:0];
            r_s6_dbig  <= r_s5_dbig || (|w_s6_dfull[44:OFF_W]);
            r_s6_a     <= w_s6_afull[OFF_W-1:0];
            r_s6_abig  <= r_s5_abig || (|w_s6_afull[33:OFF_W]);
            r_s6_iw    <= n_s6_iw;
            // Stage 7: an element size of zero clears any earlier destination overflow.
            r_s7_shape <= r_s6_shape;
            r_s7_rng   <= r_s6_rng;
            r_s7_d     <= w_s7_dfull[OFF_W-1:0];
            r_s7_dbig  <= (r_s6_dbig && !w_eb_zero) || (|w_s7_dfull[35:OFF_W]);
            r_s7_a     <= w_s7_afull[OFF_W-1:0];
            r_s7_abig  <= r_s6_abig || (|w_s7_afull[44:OFF_W]);
            // Stage 8
            r_s8_shape <= r_s7_shape;
            r_s8_rng   <= r_s7_rng;
            r_s8_d     <= r_s7_d;
            r_s8_dbig  <= r_s7_dbig;
            r_s8_a     <= w_s8_afull[OFF_W-1:0];
            r_s8_abig  <= (r_s7_abig && !w_eb_zero) || (|w_s8_afull[35:OFF_W]);
        end
    end

    // ------------------------------------------------------------------
    // Status selection and saturation
    // ------------------------------------------------------------------
    always_comb begin
        logic v_src_over;
        logic v_dst_over;
        v_src_over = r_s8_abig || (r_s8_a > LIMIT);
        v_dst_over = r_s8_dbig || (r_s8_d > LIMIT);
        w_result   = '0;
        if (r_s8_shape) begin
            w_result.status = ST_SHAPE;
        end else if (r_s8_rng) begin
            w_result.status = ST_RANGE;
        end else begin
            w_result.src    = v_src_over ? LIMIT : r_s8_a;
            w_result.dst    = v_dst_over ? LIMIT : r_s8_d;
            w_result.status = (v_src_over || v_dst_over) ? ST_OVER : ST_OK;
        end
    end

    // ------------------------------------------------------------------
    // Output register with skid entry
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (r_s8_v) begin
            if (r_out_valid && i_out_stall) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (w_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_take) begin
                r_out <= r_skid;
            end
        end else if (r_s8_v) begin
            if (r_out_valid && i_out_stall) begin
                r_skid <= w_result;
            end else begin
                r_out <= w_result;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_src_offset = r_out.src;
    assign o_dst_offset = r_out.dst;
    assign o_status     = r_out.status;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`ifndef SYNTHESIS
    // The skid entry only ever holds a beat behind a full output register.
    a_skid_behind_out: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid
    ) else $error("skid entry full while output register is empty");

    // The skid entry fills only when the output was stalled.
    a_skid_fill_cause: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && i_out_stall)
    ) else $error("skid entry filled without an output stall");

    // Shape and range faults carry zero offsets.
    a_fault_zero: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_SHAPE || o_status == ST_RANGE))
            |-> (o_src_offset == '0 && o_dst_offset == '0)
    ) else $error("faulted beat carries a nonzero offset");

    // An overflow beat has at least one offset pinned at the limit.
    a_over_saturates: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_OVER)
            |-> (o_src_offset == LIMIT || o_dst_offset == LIMIT)
    ) else $error("overflow beat without a saturated offset");
`endif

endmodule
`default_nettype wire
